@@ src/ntt_polynomial_multiplier_core_defines.svh @@
// Assertion macros shared by the polynomial multiplier files.
`ifndef NTT_POLYNOMIAL_MULTIPLIER_CORE_DEFINES_SVH
`define NTT_POLYNOMIAL_MULTIPLIER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Implication checked on every rising edge outside reset.
`define NPM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npm assertion failed");
// Invariant checked on every rising edge outside reset.
`define NPM_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("npm invariant failed");
`else
`define NPM_ASSERT_IMP(label, clk, rst, ante, cons)
`define NPM_ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

@@ src/npm_pkg.sv @@
// Types and constants of the NTT polynomial multiplier.
package npm_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam int DW = 32;

  // Request opcodes.
  localparam logic [1:0] OP_LOAD1 = 2'd0;
  localparam logic [1:0] OP_LOAD2 = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LONG  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_ROOT    = 1'b1;
  localparam logic [DW-1:0] MODULUS_RESET = 32'd998244353;
  localparam logic [DW-1:0] ROOT_RESET    = 32'd3;

  typedef struct packed {
    logic [1:0]    opcode;
    logic [DW-1:0] coeff;
    logic [AW-1:0] index;
  } in_t;

  typedef struct packed {
    logic [DW-1:0] value;
    logic [CW-1:0] product_length;
    logic [1:0]    status;
  } out_t;

  // Control into the modular unit.
  typedef struct packed {
    logic start;
    logic mul;
  } mu_req_t;

  // Status from the modular unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mu_stat_t;

endpackage

@@ src/ntt_polynomial_multiplier_core.sv @@
// A load reduces its coefficient in the modular unit and stores it without a result; a read
// answers from the store. A start takes roughly 3 * (N/2) * log2(N) butterflies, plus
// the twiddle exponentiations; a too-long or empty start answers without a transform.
// Throughput is set by the single shared modular unit, which reduces one bit per cycle.
// Reset is synchronous: counts, product length and handshake clear, registers go to
// their defaults; the coefficient stores are not cleared.
`include "ntt_polynomial_multiplier_core_defines.svh"

module ntt_polynomial_multiplier_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  npm_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output npm_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [npm_pkg::DW-1:0]    cfg_data
);

  typedef enum logic [35:0] {
    S_IDLE    = 36'h0_0000_0001,
    S_LDW     = 36'h0_0000_0002,
    S_RDV     = 36'h0_0000_0004,
    S_FIN     = 36'h0_0000_0008,
    S_SIZE    = 36'h0_0000_0010,
    S_PAD1    = 36'h0_0000_0020,
    S_PAD2    = 36'h0_0000_0040,
    S_TFS     = 36'h0_0000_0080,
    S_BR      = 36'h0_0000_0100,
    S_BR_A    = 36'h0_0000_0200,
    S_BR_B    = 36'h0_0000_0400,
    S_BR_C    = 36'h0_0000_0800,
    S_ST_INIT = 36'h0_0000_1000,
    S_ST_INV  = 36'h0_0000_2000,
    S_ST_GO   = 36'h0_0000_4000,
    S_BLK     = 36'h0_0000_8000,
    S_BF      = 36'h0_0001_0000,
    S_BF_A    = 36'h0_0002_0000,
    S_BF_B    = 36'h0_0004_0000,
    S_BF_C    = 36'h0_0008_0000,
    S_BF_D    = 36'h0_0010_0000,
    S_BF_E    = 36'h0_0020_0000,
    S_BF_F    = 36'h0_0040_0000,
    S_SC_INIT = 36'h0_0080_0000,
    S_SC_GO   = 36'h0_0100_0000,
    S_SC      = 36'h0_0200_0000,
    S_SC_A    = 36'h0_0400_0000,
    S_SC_B    = 36'h0_0800_0000,
    S_TF_DONE = 36'h0_1000_0000,
    S_PM      = 36'h0_2000_0000,
    S_PM_A    = 36'h0_4000_0000,
    S_PM_B    = 36'h0_8000_0000,
    S_PW      = 36'h1_0000_0000,
    S_PW_A    = 36'h2_0000_0000,
    S_PW_B    = 36'h4_0000_0000,
    S_WAITM   = 36'h8_0000_0000
  } state_t;

  typedef enum logic [2:0] {
    PH_FWD1 = 3'b001,
    PH_FWD2 = 3'b010,
    PH_INV  = 3'b100
  } phase_t;

  localparam int AW = npm_pkg::AW;
  localparam int CW = npm_pkg::CW;

  state_t  state;
  state_t  mret;
  state_t  pret;
  phase_t  phase;

  logic [31:0]   p;
  logic [31:0]   rt;
  logic [CW-1:0] cnt1;
  logic [CW-1:0] cnt2;
  logic [CW-1:0] rlen;
  logic [CW-1:0] n;
  logic [3:0]    logn;
  logic [CW-1:0] k;
  logic [CW-1:0] pad2;
  logic          sel;
  logic          backward;
  logic [3:0]    s;
  logic [CW-1:0] blk;
  logic [AW-1:0] j;
  logic [31:0]   w;
  logic [31:0]   step;
  logic [31:0]   u;
  logic [31:0]   tv;
  logic [31:0]   pw_acc;
  logic [31:0]   pw_b;
  logic [31:0]   pw_e;
  logic [31:0]   res_value;
  logic [CW-1:0] res_len;
  logic [1:0]    res_status;

  logic [31:0]   first_mem [npm_pkg::MAX_POINTS];
  logic [31:0]   second_mem [npm_pkg::MAX_POINTS];
  logic [31:0]   rdata1;
  logic [31:0]   rdata2;
  logic [31:0]   rdv;

  logic          in_acc;
  logic [CW-1:0] cnt_sel;
  logic [CW:0]   plen;
  logic [31:0]   one;
  logic [31:0]   pm2;
  logic [31:0]   e1;
  logic [CW-1:0] half;
  logic [CW-1:0] len;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [AW-1:0] kr;
  logic [AW-1:0] rv;

  logic          we1;
  logic          we2;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          launch;
  state_t        launch_ret;

  npm_pkg::mu_req_t  mu_req;
  npm_pkg::mu_stat_t mu_stat;
  logic [31:0]       mu_a;
  logic [31:0]       mu_b;
  logic [63:0]       mu_wide;
  logic [31:0]       mu_res;

  npm_mod_unit u_mod (
    .clk     (clk),
    .rst     (rst),
    .req     (mu_req),
    .modulus (p),
    .a       (mu_a),
    .b       (mu_b),
    .wide    (mu_wide),
    .stat    (mu_stat),
    .res     (mu_res)
  );

  // Handshake and derived values.
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cnt_sel  = (in_data.opcode == npm_pkg::OP_LOAD2) ? cnt2 : cnt1;
  assign plen     = {1'b0, cnt1} + {1'b0, cnt2} - {{CW{1'b0}}, 1'b1};
  assign one      = (p > 32'd1) ? 32'd1 : 32'd0;
  assign pm2      = (p >= 32'd2) ? p - 32'd2 : 32'd0;
  assign e1       = (p == 32'd0) ? 32'd0 : (p - 32'd1) >> s;
  assign half     = CW'(1) << (s - 4'd1);
  assign len      = CW'(1) << s;
  assign lo       = blk[AW-1:0] + j;
  assign hi       = lo + half[AW-1:0];
  assign rdv      = sel ? rdata2 : rdata1;

  // Bit-reversed partner of k within log2(n) bits.
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      kr[i] = k[AW-1-i];
    end
    rv = kr >> (4'(AW) - logn);
  end

  // Coefficient stores.
  always_ff @(posedge clk) begin
    rdata1 <= first_mem[rd_addr];
    rdata2 <= second_mem[rd_addr];
    if (we1) begin
      first_mem[wr_addr] <= wr_data;
    end
    if (we2) begin
      second_mem[wr_addr] <= wr_data;
    end
  end

  // Store addressing and modular unit requests for each step.
  always_comb begin
    rd_addr    = k[AW-1:0];
    wr_addr    = k[AW-1:0];
    wr_data    = mu_res;
    we1        = 1'b0;
    we2        = 1'b0;
    launch     = 1'b0;
    launch_ret = S_IDLE;
    mu_req.mul = 1'b0;
    mu_a       = '0;
    mu_b       = '0;
    mu_wide    = '0;
    case (state)
      S_IDLE: begin
        rd_addr = in_data.index;
        if (in_acc && (in_data.opcode == npm_pkg::OP_LOAD1 ||
                       in_data.opcode == npm_pkg::OP_LOAD2) &&
            cnt_sel < CW'(npm_pkg::MAX_POINTS)) begin
          launch     = 1'b1;
          launch_ret = S_LDW;
          mu_wide    = {32'b0, in_data.coeff};
        end
      end
      S_LDW: begin
        wr_addr = sel ? cnt2[AW-1:0] : cnt1[AW-1:0];
        we1     = !sel;
        we2     = sel;
      end
      S_PAD1: begin
        wr_data = '0;
        we1     = (k < n);
      end
      S_PAD2: begin
        wr_data = '0;
        we2     = (k < n);
      end
      S_BR_A: rd_addr = rv;
      S_BR_B: begin
        wr_data = rdv;
        we1     = !sel;
        we2     = sel;
      end
      S_BR_C: begin
        wr_addr = rv;
        wr_data = u;
        we1     = !sel;
        we2     = sel;
      end
      S_BF: rd_addr = lo;
      S_BF_A: rd_addr = hi;
      S_BF_B: begin
        launch     = 1'b1;
        launch_ret = S_BF_C;
        mu_req.mul = 1'b1;
        mu_a       = rdv;
        mu_b       = w;
      end
      S_BF_C: begin
        launch     = 1'b1;
        launch_ret = S_BF_D;
        mu_wide    = {31'b0, {1'b0, u} + {1'b0, mu_res}};
      end
      S_BF_D: begin
        wr_addr    = lo;
        we1        = !sel;
        we2        = sel;
        launch     = 1'b1;
        launch_ret = S_BF_E;
        mu_wide    = {30'b0, {2'b0, u} + {2'b0, p} - {2'b0, tv}};
      end
      S_BF_E: begin
        wr_addr    = hi;
        we1        = !sel;
        we2        = sel;
        launch     = 1'b1;
        launch_ret = S_BF_F;
        mu_req.mul = 1'b1;
        mu_a       = w;
        mu_b       = step;
      end
      S_SC_A: begin
        launch     = 1'b1;
        launch_ret = S_SC_B;
        mu_req.mul = 1'b1;
        mu_a       = rdv;
        mu_b       = step;
      end
      S_SC_B: begin
        we1 = !sel;
        we2 = sel;
      end
      S_PM_A: begin
        launch     = 1'b1;
        launch_ret = S_PM_B;
        mu_req.mul = 1'b1;
        mu_a       = rdata1;
        mu_b       = rdata2;
      end
      S_PM_B: we1 = 1'b1;
      S_PW: begin
        if (pw_e != 32'd0) begin
          launch     = 1'b1;
          mu_req.mul = 1'b1;
          if (pw_e[0]) begin
            launch_ret = S_PW_A;
            mu_a       = pw_acc;
            mu_b       = pw_b;
          end else begin
            launch_ret = S_PW_B;
            mu_a       = pw_b;
            mu_b       = pw_b;
          end
        end
      end
      S_PW_A: begin
        launch     = 1'b1;
        launch_ret = S_PW_B;
        mu_req.mul = 1'b1;
        mu_a       = pw_b;
        mu_b       = pw_b;
      end
      default: rd_addr = k[AW-1:0];
    endcase
    mu_req.start = launch;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt1      <= '0;
      cnt2      <= '0;
      rlen      <= '0;
      p         <= npm_pkg::MODULUS_RESET;
      rt        <= npm_pkg::ROOT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          npm_pkg::REG_MODULUS: p <= cfg_data;
          npm_pkg::REG_ROOT:    rt <= cfg_data;
          default:              p <= cfg_data;
        endcase
      end
      // The result register empties when taken, unless a new result refills it.
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data.opcode)
              npm_pkg::OP_LOAD1, npm_pkg::OP_LOAD2: begin
                sel <= (in_data.opcode == npm_pkg::OP_LOAD2);
              end
              npm_pkg::OP_START: begin
                cnt1       <= '0;
                cnt2       <= '0;
                res_value  <= '0;
                res_status <= npm_pkg::ST_OK;
                if (cnt1 == '0 || cnt2 == '0) begin
                  res_len <= '0;
                  rlen    <= '0;
                  state   <= S_FIN;
                end else if (plen > (CW+1)'(npm_pkg::MAX_POINTS)) begin
                  res_len    <= plen[CW-1:0];
                  res_status <= npm_pkg::ST_LONG;
                  rlen       <= '0;
                  state      <= S_FIN;
                end else begin
                  res_len <= plen[CW-1:0];
                  rlen    <= plen[CW-1:0];
                  n       <= CW'(1);
                  logn    <= '0;
                  k       <= cnt1;
                  pad2    <= cnt2;
                  state   <= S_SIZE;
                end
              end
              default: begin
                res_len <= rlen;
                if ({1'b0, in_data.index} < rlen) begin
                  state <= S_RDV;
                end else begin
                  res_value  <= '0;
                  res_status <= npm_pkg::ST_RANGE;
                  state      <= S_FIN;
                end
              end
            endcase
          end
        end
        S_LDW: begin
          if (sel) begin
            cnt2 <= cnt2 + CW'(1);
          end else begin
            cnt1 <= cnt1 + CW'(1);
          end
          state <= S_IDLE;
        end
        S_RDV: begin
          res_value  <= rdata1;
          res_status <= npm_pkg::ST_OK;
          state      <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid               <= 1'b1;
            out_data.value          <= res_value;
            out_data.product_length <= res_len;
            out_data.status         <= res_status;
            state                   <= S_IDLE;
          end
        end
        // Smallest power of two covering the product.
        S_SIZE: begin
          if (n < rlen) begin
            n    <= n << 1;
            logn <= logn + 4'd1;
          end else begin
            state <= S_PAD1;
          end
        end
        S_PAD1: begin
          if (k < n) begin
            k <= k + CW'(1);
          end else begin
            k     <= pad2;
            state <= S_PAD2;
          end
        end
        S_PAD2: begin
          if (k < n) begin
            k <= k + CW'(1);
          end else begin
            sel      <= 1'b0;
            backward <= 1'b0;
            phase    <= PH_FWD1;
            state    <= S_TFS;
          end
        end
        S_TFS: begin
          k     <= CW'(1);
          state <= S_BR;
        end
        // Bit-reversal permutation, one swap at a time.
        S_BR: begin
          if (k >= n) begin
            s     <= 4'd1;
            state <= S_ST_INIT;
          end else if (k < {1'b0, rv}) begin
            state <= S_BR_A;
          end else begin
            k <= k + CW'(1);
          end
        end
        S_BR_A: begin
          u     <= rdv;
          state <= S_BR_B;
        end
        S_BR_B: state <= S_BR_C;
        S_BR_C: begin
          k     <= k + CW'(1);
          state <= S_BR;
        end
        // Per-stage twiddle step from the root.
        S_ST_INIT: begin
          if (s > logn) begin
            state <= backward ? S_SC_INIT : S_TF_DONE;
          end else begin
            pw_acc <= one;
            pw_b   <= rt;
            pw_e   <= e1;
            pret   <= S_ST_INV;
            state  <= S_PW;
          end
        end
        S_ST_INV: begin
          if (backward) begin
            pw_acc <= one;
            pw_b   <= pw_acc;
            pw_e   <= pm2;
            pret   <= S_ST_GO;
            state  <= S_PW;
          end else begin
            state <= S_ST_GO;
          end
        end
        S_ST_GO: begin
          step  <= pw_acc;
          blk   <= '0;
          state <= S_BLK;
        end
        S_BLK: begin
          if (blk >= n) begin
            s     <= s + 4'd1;
            state <= S_ST_INIT;
          end else begin
            w     <= one;
            j     <= '0;
            state <= S_BF;
          end
        end
        // Butterfly over the pair lo and hi.
        S_BF: begin
          if ({1'b0, j} >= half) begin
            blk   <= blk + len;
            state <= S_BLK;
          end else begin
            state <= S_BF_A;
          end
        end
        S_BF_A: begin
          u     <= rdv;
          state <= S_BF_B;
        end
        S_BF_C: tv <= mu_res;
        S_BF_F: begin
          w     <= mu_res;
          j     <= j + AW'(1);
          state <= S_BF;
        end
        // Inverse transform scaling by n^-1.
        S_SC_INIT: begin
          pw_acc <= one;
          pw_b   <= {{(32-CW){1'b0}}, n};
          pw_e   <= pm2;
          pret   <= S_SC_GO;
          state  <= S_PW;
        end
        S_SC_GO: begin
          step  <= pw_acc;
          k     <= '0;
          state <= S_SC;
        end
        S_SC: begin
          state <= (k >= n) ? S_TF_DONE : S_SC_A;
        end
        S_SC_B: begin
          k     <= k + CW'(1);
          state <= S_SC;
        end
        S_TF_DONE: begin
          case (phase)
            PH_FWD1: begin
              sel   <= 1'b1;
              phase <= PH_FWD2;
              state <= S_TFS;
            end
            PH_FWD2: begin
              k     <= '0;
              state <= S_PM;
            end
            default: state <= S_FIN;
          endcase
        end
        // Pointwise product into the first store.
        S_PM: begin
          if (k >= n) begin
            sel      <= 1'b0;
            backward <= 1'b1;
            phase    <= PH_INV;
            state    <= S_TFS;
          end else begin
            state <= S_PM_A;
          end
        end
        S_PM_B: begin
          k     <= k + CW'(1);
          state <= S_PM;
        end
        // Square-and-multiply exponentiation.
        S_PW: begin
          if (pw_e == 32'd0) begin
            state <= pret;
          end
        end
        S_PW_A: pw_acc <= mu_res;
        S_PW_B: begin
          pw_b  <= mu_res;
          pw_e  <= pw_e >> 1;
          state <= S_PW;
        end
        S_WAITM: begin
          if (mu_stat.done) begin
            state <= mret;
          end
        end
        // Launching states move on below.
        default: begin
        end
      endcase
      if (launch) begin
        mret  <= launch_ret;
        state <= S_WAITM;
      end
    end
  end

  // Counts stay within the store, and the shared unit is never started while busy.
  `NPM_ASSERT_ALWAYS(a_cnt_bound, clk, rst,
                     (cnt1 <= CW'(npm_pkg::MAX_POINTS)) && (cnt2 <= CW'(npm_pkg::MAX_POINTS)))
  `NPM_ASSERT_ALWAYS(a_rlen_bound, clk, rst, rlen <= CW'(npm_pkg::MAX_POINTS))
  `NPM_ASSERT_IMP(a_launch_free, clk, rst, launch, !mu_stat.busy)
  `NPM_ASSERT_IMP(a_done_waiting, clk, rst, mu_stat.done, state == S_WAITM)

endmodule

@@ src/npm_mod_unit.sv @@
// Shared modular unit: 32x32 multiply or wide operand, then bit-serial reduction.
`include "ntt_polynomial_multiplier_core_defines.svh"

module npm_mod_unit (
  input  logic                clk,
  input  logic                rst,
  input  npm_pkg::mu_req_t    req,
  input  logic [31:0]         modulus,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  input  logic [63:0]         wide,
  output npm_pkg::mu_stat_t   stat,
  output logic [31:0]         res
);

  typedef enum logic [2:0] {
    MU_IDLE = 3'b001,
    MU_MUL  = 3'b010,
    MU_DIV  = 3'b100
  } mu_state_t;

  mu_state_t   state;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [63:0] dvd;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        done;
  logic [32:0] trial;
  logic [31:0] rem_next;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {rem, dvd[63]};
    if (trial >= {1'b0, modulus}) begin
      rem_next = 32'(trial - {1'b0, modulus});
    end else begin
      rem_next = trial[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MU_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        MU_IDLE: begin
          if (req.start) begin
            rem <= '0;
            cnt <= '0;
            if (req.mul) begin
              opa   <= a;
              opb   <= b;
              state <= MU_MUL;
            end else begin
              dvd   <= wide;
              state <= MU_DIV;
            end
          end
        end
        MU_MUL: begin
          dvd   <= {32'b0, opa} * {32'b0, opb};
          state <= MU_DIV;
        end
        MU_DIV: begin
          dvd <= {dvd[62:0], 1'b0};
          rem <= rem_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            res   <= (modulus == 32'd0) ? 32'd0 : rem_next;
            done  <= 1'b1;
            state <= MU_IDLE;
          end
        end
        default: state <= MU_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != MU_IDLE);
  assign stat.done = done;

  // The unit is only started when free, and its remainders stay reduced.
  `NPM_ASSERT_IMP(a_start_idle, clk, rst, req.start, state == MU_IDLE)
  `NPM_ASSERT_IMP(a_rem_reduced, clk, rst, (state == MU_DIV) && (modulus != 32'd0),
                  rem < modulus)
  `NPM_ASSERT_IMP(a_res_reduced, clk, rst, done, (modulus == 32'd0) || (res < modulus))

endmodule
